// ===== design/assert_macros.svh =====
// Assertion helpers shared by the odometry RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset
`define ODO_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising clock edge, reset included
`define ODO_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/odo_pkg.sv =====
// ----------------------------------------------------------------------------
// odo_pkg
// Shared types, constants and saturation helpers for the odometry block.
// ----------------------------------------------------------------------------
package odo_pkg;

    // Multiplier operand and product widths
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;

    localparam int CORDIC_STEPS_DEF = 24;

    // Fixed point constants, Q2.30 angles
    localparam logic signed [31:0] Q30_ONE     = 32'sd1073741824;
    localparam logic signed [34:0] TWO_PI      = 35'sd6746518852;
    localparam logic signed [34:0] PI          = 35'sd3373259426;
    localparam logic signed [34:0] HALF_PI     = 35'sd1686629713;
    localparam logic signed [34:0] CORDIC_GAIN = 35'sd652032874;
    // 2*pi * 2^21 lifts any scaled angle above zero without moving its residue
    localparam logic [54:0] MOD_BIAS = 55'(64'd6746518852 << 21);
    localparam int MOD_BITS = 55;

    // Register map
    typedef enum logic [1:0] {
        REG_SPEED_OFFSET = 2'd0,
        REG_SPEED_GAIN   = 2'd1,
        REG_INV_TRACK    = 2'd2
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_RV,
        ST_MUL_LV,
        ST_MUL_RATE,
        ST_MUL_VX,
        ST_MUL_VY,
        ST_MUL_DX,
        ST_MUL_DY,
        ST_MUL_PHI,
        ST_MOD,
        ST_FOLD,
        ST_CORDIC,
        ST_MUL_C1,
        ST_MUL_C2,
        ST_MUL_C3,
        ST_MUL_C4,
        ST_DONE
    } odo_state_t;

    // atan(2^-i) in Q2.30
    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'd843314856;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043836;
            5'd3:  v = 30'd133525158;
            5'd4:  v = 30'd67021686;
            5'd5:  v = 30'd33543515;
            5'd6:  v = 30'd16775850;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194282;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048575;
            5'd11: v = 30'd524287;
            5'd12: v = 30'd262143;
            5'd13: v = 30'd131071;
            5'd14: v = 30'd65535;
            5'd15: v = 30'd32767;
            5'd16: v = 30'd16383;
            5'd17: v = 30'd8191;
            5'd18: v = 30'd4095;
            5'd19: v = 30'd2047;
            5'd20: v = 30'd1023;
            5'd21: v = 30'd511;
            5'd22: v = 30'd255;
            5'd23: v = 30'd127;
            5'd24: v = 30'd63;
            5'd25: v = 30'd31;
            5'd26: v = 30'd15;
            5'd27: v = 30'd8;
            5'd28: v = 30'd4;
            5'd29: v = 30'd2;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [68:0] v);
        logic signed [31:0] r;
        if (v > 69'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -69'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [68:0] v);
        logic signed [47:0] r;
        if (v > 69'sd140737488355327)
            r = 48'sh7fffffffffff;
        else if (v < -69'sd140737488355328)
            r = 48'sh800000000000;
        else
            r = v[47:0];
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_unit(input logic signed [68:0] v);
        logic signed [31:0] r;
        if (v > 69'sd1073741824)
            r = Q30_ONE;
        else if (v < -69'sd1073741824)
            r = -Q30_ONE;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== design/odo_mul.sv =====
// ----------------------------------------------------------------------------
// odo_mul
// Bit-serial signed multiplier: one multiplier bit per cycle, MSB weighted
// negative, product held until the next start.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module odo_mul
    import odo_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [MUL_W-1:0]  a,
    input  logic signed [MUL_W-1:0]  b,
    output logic                     busy,
    output logic                     done,
    output logic signed [PROD_W-1:0] p
);

    localparam int CNT_W = $clog2(MUL_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(MUL_W - 1);

    logic                     active_reg;
    logic                     done_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [PROD_W-1:0] mc_reg;
    logic [MUL_W-1:0]         mp_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [PROD_W-1:0] acc_next;

    // Partial product add; the sign bit of the multiplier subtracts
    always_comb
    begin
        acc_next = acc_reg;
        if (mp_reg[0])
        begin
            if (cnt_reg == LAST)
                acc_next = acc_reg - mc_reg;
            else
                acc_next = acc_reg + mc_reg;
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !active_reg)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= '0;
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    // Operand shift registers and accumulator
    always_ff @(posedge clk)
    begin
        if (start && !active_reg)
        begin
            mc_reg  <= PROD_W'(a);
            mp_reg  <= b;
            acc_reg <= '0;
        end
        else if (active_reg)
        begin
            mc_reg  <= mc_reg <<< 1;
            mp_reg  <= mp_reg >> 1;
            acc_reg <= acc_next;
        end
    end

    assign busy = active_reg || done_reg;
    assign done = done_reg;
    assign p    = acc_reg;

    `ODO_ASSERT(a_done_after_last, active_reg && (cnt_reg == LAST) |=> done_reg && !active_reg,
                "multiplier did not finish after its last bit")
    `ODO_ASSERT(a_done_single, done_reg |=> !done_reg,
                "multiplier done held for more than one cycle")

endmodule

// ===== design/diff_drive_odometry.sv =====
// ----------------------------------------------------------------------------
// diff_drive_odometry
// Differential-drive dead-reckoning odometry in fixed point.
// ----------------------------------------------------------------------------
// Each accepted transaction updates wheel speeds (when readings_seen is set),
// advances the position along the old heading, rotates the cos/sin heading
// pair by turn_rate * step_time and accumulates the heading angle. One item is
// worked at a time; in_stall is high until its result is registered. All
// multiplies share one bit-serial multiplier: twelve with readings_seen set
// and three fewer, the speed and rate ones skipped, otherwise. The angle step
// is reduced bit-serially modulo 2*pi, folded and fed to the one-step-a-cycle
// CORDIC before the rotation multiplies. The result waits in an output
// register, so the next transaction starts while it is unread.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module diff_drive_odometry
    import odo_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // APB configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // Input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        right_reading,
    input  logic [15:0]        left_reading,
    input  logic [23:0]        step_time,
    input  logic               readings_seen,
    // Output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [47:0] pos_x,
    output logic signed [47:0] pos_y,
    output logic signed [31:0] heading,
    output logic signed [31:0] heading_cos,
    output logic signed [31:0] heading_sin,
    output logic signed [31:0] linear_speed,
    output logic signed [31:0] turn_rate
);

    localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);
    localparam logic [5:0] MOD_LAST  = 6'(MOD_BITS - 1);

    // Configuration
    logic [15:0]        speed_offset_reg;
    logic signed [31:0] speed_gain_reg;
    logic [30:0]        inv_track_reg;

    // Latched transaction
    logic [15:0] right_reg, left_reg;
    logic [23:0] dt_reg;

    // Odometry state
    logic signed [31:0] rv_reg, lv_reg;
    logic signed [31:0] speed_reg, rate_reg;
    logic signed [33:0] vx_reg, vy_reg;
    logic signed [47:0] x_reg, y_reg;
    logic signed [31:0] angle_reg, cos_reg, sin_reg;
    logic signed [31:0] nc_reg;
    logic signed [PROD_W-1:0] t_reg;

    // Angle reduction and CORDIC
    logic [54:0]        mod_src_reg;
    logic [32:0]        rem_reg;
    logic [5:0]         mod_cnt_reg;
    logic signed [34:0] cx_reg, cy_reg, cz_reg;
    logic               neg_reg;
    logic [4:0]         step_reg;

    odo_state_t state_reg, state_next;

    // Output register
    logic               out_valid_reg;
    logic signed [47:0] out_x_reg, out_y_reg;
    logic signed [31:0] out_angle_reg, out_cos_reg, out_sin_reg;
    logic signed [31:0] out_speed_reg, out_rate_reg;

    // Multiplier hookup
    logic                     mul_start, mul_busy, mul_done;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic                     mul_state;

    logic               in_accept, cfg_write, out_free;
    logic signed [31:0] lv_sat;
    logic signed [34:0] c_val, s_val;
    logic [33:0]        mod_shift;
    logic signed [34:0] fold_r, fold_z;
    logic               fold_neg;
    logic signed [34:0] cx_sh, cy_sh, atan_v;

    assign in_accept = in_valid && !in_stall;
    assign cfg_write = psel && penable && pwrite && pready;
    assign out_free  = !out_valid_reg || !out_stall;
    assign pready    = 1'b1;

    odo_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .busy  (mul_busy),
        .done  (mul_done),
        .p     (mul_p)
    );

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_offset_reg <= '0;
            speed_gain_reg   <= 32'sd65536;
            inv_track_reg    <= 31'd65536;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(paddr[3:2]))
                REG_SPEED_OFFSET: speed_offset_reg <= pwdata[15:0];
                REG_SPEED_GAIN:   speed_gain_reg   <= pwdata;
                REG_INV_TRACK:    inv_track_reg    <= pwdata[30:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_reg_t'(paddr[3:2]))
            REG_SPEED_OFFSET: prdata = {16'b0, speed_offset_reg};
            REG_SPEED_GAIN:   prdata = speed_gain_reg;
            REG_INV_TRACK:    prdata = {1'b0, inv_track_reg};
            default:          prdata = '0;
        endcase
    end

    // Rotated unit vector with the fold applied
    assign c_val = neg_reg ? -cx_reg : cx_reg;
    assign s_val = neg_reg ? -cy_reg : cy_reg;

    // Multiplier operand select
    always_comb
    begin
        mul_state = 1'b1;
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            ST_MUL_RV:
            begin
                mul_a = MUL_W'(speed_gain_reg);
                mul_b = $signed({18'b0, right_reg}) - $signed({18'b0, speed_offset_reg});
            end
            ST_MUL_LV:
            begin
                mul_a = MUL_W'(speed_gain_reg);
                mul_b = $signed({18'b0, left_reg}) - $signed({18'b0, speed_offset_reg});
            end
            ST_MUL_RATE:
            begin
                mul_a = MUL_W'(rv_reg) - MUL_W'(lv_reg);
                mul_b = $signed({3'b0, inv_track_reg});
            end
            ST_MUL_VX:
            begin
                mul_a = MUL_W'(speed_reg);
                mul_b = MUL_W'(cos_reg);
            end
            ST_MUL_VY:
            begin
                mul_a = MUL_W'(speed_reg);
                mul_b = MUL_W'(sin_reg);
            end
            ST_MUL_DX:
            begin
                mul_a = vx_reg;
                mul_b = $signed({10'b0, dt_reg});
            end
            ST_MUL_DY:
            begin
                mul_a = vy_reg;
                mul_b = $signed({10'b0, dt_reg});
            end
            ST_MUL_PHI:
            begin
                mul_a = MUL_W'(rate_reg);
                mul_b = $signed({10'b0, dt_reg});
            end
            ST_MUL_C1:
            begin
                mul_a = MUL_W'(cos_reg);
                mul_b = MUL_W'(c_val);
            end
            ST_MUL_C2:
            begin
                mul_a = MUL_W'(sin_reg);
                mul_b = MUL_W'(s_val);
            end
            ST_MUL_C3:
            begin
                mul_a = MUL_W'(sin_reg);
                mul_b = MUL_W'(c_val);
            end
            ST_MUL_C4:
            begin
                mul_a = MUL_W'(cos_reg);
                mul_b = MUL_W'(s_val);
            end
            default: mul_state = 1'b0;
        endcase
    end

    assign mul_start = mul_state && !mul_busy;
    assign lv_sat    = sat32(69'(mul_p));

    // Restoring reduction step modulo 2*pi
    assign mod_shift = {rem_reg, mod_src_reg[54]};

    // Fold the residue in [0, 2*pi) into [-pi/2, pi/2]
    always_comb
    begin
        fold_r   = $signed({2'b0, rem_reg});
        fold_z   = fold_r;
        fold_neg = 1'b0;
        if (fold_r > PI)
        begin
            if (fold_r < TWO_PI - HALF_PI)
            begin
                fold_z   = fold_r - TWO_PI + PI;
                fold_neg = 1'b1;
            end
            else
                fold_z = fold_r - TWO_PI;
        end
        else if (fold_r > HALF_PI)
        begin
            fold_z   = fold_r - PI;
            fold_neg = 1'b1;
        end
    end

    // CORDIC step terms
    assign cx_sh  = cx_reg >>> step_reg;
    assign cy_sh  = cy_reg >>> step_reg;
    assign atan_v = $signed({5'b0, atan_q30(step_reg)});

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                    state_next = readings_seen ? ST_MUL_RV : ST_MUL_VX;
            end
            ST_MUL_RV:   if (mul_done) state_next = ST_MUL_LV;
            ST_MUL_LV:   if (mul_done) state_next = ST_MUL_RATE;
            ST_MUL_RATE: if (mul_done) state_next = ST_MUL_VX;
            ST_MUL_VX:   if (mul_done) state_next = ST_MUL_VY;
            ST_MUL_VY:   if (mul_done) state_next = ST_MUL_DX;
            ST_MUL_DX:   if (mul_done) state_next = ST_MUL_DY;
            ST_MUL_DY:   if (mul_done) state_next = ST_MUL_PHI;
            ST_MUL_PHI:  if (mul_done) state_next = ST_MOD;
            ST_MOD:      if (mod_cnt_reg == MOD_LAST) state_next = ST_FOLD;
            ST_FOLD:     state_next = ST_CORDIC;
            ST_CORDIC:   if (step_reg == LAST_STEP) state_next = ST_MUL_C1;
            ST_MUL_C1:   if (mul_done) state_next = ST_MUL_C2;
            ST_MUL_C2:   if (mul_done) state_next = ST_MUL_C3;
            ST_MUL_C3:   if (mul_done) state_next = ST_MUL_C4;
            ST_MUL_C4:   if (mul_done) state_next = ST_DONE;
            ST_DONE:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Odometry state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg     <= '0;
            y_reg     <= '0;
            angle_reg <= '0;
            cos_reg   <= Q30_ONE;
            sin_reg   <= '0;
            speed_reg <= '0;
            rate_reg  <= '0;
        end
        else if (mul_done)
        begin
            case (state_reg)
                ST_MUL_LV:
                    speed_reg <= 32'((33'(rv_reg) + 33'(lv_sat)) >>> 1);
                ST_MUL_RATE:
                    rate_reg <= sat32(69'(mul_p >>> 16));
                ST_MUL_DX:
                    x_reg <= sat48(69'(x_reg) + 69'(mul_p >>> 16));
                ST_MUL_DY:
                    y_reg <= sat48(69'(y_reg) + 69'(mul_p >>> 16));
                ST_MUL_PHI:
                    angle_reg <= sat32(69'(angle_reg) + 69'(mul_p >>> 16));
                ST_MUL_C4:
                begin
                    cos_reg <= nc_reg;
                    sin_reg <= clamp_unit((69'(t_reg) + 69'(mul_p)) >>> 30);
                end
                default: ;
            endcase
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            right_reg <= right_reading;
            left_reg  <= left_reading;
            dt_reg    <= step_time;
        end
        if (mul_done)
        begin
            case (state_reg)
                ST_MUL_RV:  rv_reg <= sat32(69'(mul_p));
                ST_MUL_LV:  lv_reg <= lv_sat;
                ST_MUL_VX:  vx_reg <= 34'(mul_p >>> 30);
                ST_MUL_VY:  vy_reg <= 34'(mul_p >>> 30);
                ST_MUL_PHI:
                begin
                    mod_src_reg <= 55'(56'(mul_p >>> 2) + $signed({1'b0, MOD_BIAS}));
                    rem_reg     <= '0;
                    mod_cnt_reg <= '0;
                end
                ST_MUL_C1:  t_reg <= mul_p;
                ST_MUL_C2:  nc_reg <= clamp_unit((69'(t_reg) - 69'(mul_p)) >>> 30);
                ST_MUL_C3:  t_reg <= mul_p;
                default: ;
            endcase
        end
        case (state_reg)
            ST_MOD:
            begin
                if (mod_shift >= 34'(TWO_PI))
                    rem_reg <= 33'(mod_shift - 34'(TWO_PI));
                else
                    rem_reg <= mod_shift[32:0];
                mod_src_reg <= mod_src_reg << 1;
                mod_cnt_reg <= mod_cnt_reg + 1'b1;
            end
            ST_FOLD:
            begin
                cz_reg   <= fold_z;
                neg_reg  <= fold_neg;
                cx_reg   <= CORDIC_GAIN;
                cy_reg   <= '0;
                step_reg <= '0;
            end
            ST_CORDIC:
            begin
                if (cz_reg >= 0)
                begin
                    cx_reg <= cx_reg - cy_sh;
                    cy_reg <= cy_reg + cx_sh;
                    cz_reg <= cz_reg - atan_v;
                end
                else
                begin
                    cx_reg <= cx_reg + cy_sh;
                    cy_reg <= cy_reg - cx_sh;
                    cz_reg <= cz_reg + atan_v;
                end
                step_reg <= step_reg + 1'b1;
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if ((state_reg == ST_DONE) && out_free)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_x_reg     <= x_reg;
            out_y_reg     <= y_reg;
            out_angle_reg <= angle_reg;
            out_cos_reg   <= cos_reg;
            out_sin_reg   <= sin_reg;
            out_speed_reg <= speed_reg;
            out_rate_reg  <= rate_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pos_x        = out_x_reg;
    assign pos_y        = out_y_reg;
    assign heading      = out_angle_reg;
    assign heading_cos  = out_cos_reg;
    assign heading_sin  = out_sin_reg;
    assign linear_speed = out_speed_reg;
    assign turn_rate    = out_rate_reg;

    `ODO_ASSERT(a_cos_unit, (cos_reg <= Q30_ONE) && (cos_reg >= -Q30_ONE),
                "heading cosine left the unit range")
    `ODO_ASSERT(a_done_waits, (state_reg == ST_DONE) && out_valid_reg && out_stall |=> state_reg == ST_DONE,
                "result finished over an unread output")
    `ODO_ASSERT(a_cordic_bounded, (state_reg == ST_CORDIC) |-> step_reg <= LAST_STEP,
                "CORDIC ran past its step count")

endmodule

// ===== tb/tb_diff_drive_odometry.sv =====
// ----------------------------------------------------------------------------
// tb_diff_drive_odometry
// Self-checking bench for the fixed-point differential-drive odometry block.
// ----------------------------------------------------------------------------
// Items are sent in bursts, and each one updates a pose predictor that lives in
// the bench. Every result that comes back is checked field by field against
// the oldest prediction. The gain, offset and track registers are rewritten
// over the APB port between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module tb_diff_drive_odometry;
    import odo_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_LIMIT  = 3000000;
    localparam int DRAIN_WAIT = 700;

    typedef struct packed {
        logic signed [47:0] px;
        logic signed [47:0] py;
        logic signed [31:0] hd;
        logic signed [31:0] hc;
        logic signed [31:0] hs;
        logic signed [31:0] ls;
        logic signed [31:0] tr;
    } pose_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [15:0] right_reading = '0, left_reading = '0;
    logic [23:0] step_time = '0;
    logic readings_seen = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [47:0] pos_x, pos_y;
    logic signed [31:0] heading, heading_cos, heading_sin, linear_speed, turn_rate;

    diff_drive_odometry u_top (.*);

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Predictor state
    longint unsigned p_offset, p_itw;
    longint p_gain;
    longint p_x, p_y, p_ang, p_cos, p_sin, p_speed, p_rate;
    pose_t pose_queue[$];
    int errors = 0;
    int n_sent = 0, n_checked = 0;
    longint cycles = 0;
    int stall_mode = 0;      // 0 random, 1 none, 2 long hold
    int hold_cycles = 0;

    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip(longint v, int bits);
        longint hi, lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic longint unit_clip(longint v);
        return v > 64'sd1073741824 ? 64'sd1073741824 :
               (v < -64'sd1073741824 ? -64'sd1073741824 : v);
    endfunction

    // Fixed CORDIC rotation of angle a (Q2.30), returns cos and sin
    task automatic rotate_unit(input longint a, output longint c, output longint s);
        longint r, x, y, nx;
        bit flip;
        r = a % longint'(TWO_PI);
        x = longint'(CORDIC_GAIN);
        y = 0;
        flip = 0;
        if (r < 0) r += longint'(TWO_PI);
        if (r > longint'(PI)) r -= longint'(TWO_PI);
        if (r > longint'(HALF_PI))
        begin
            r -= longint'(PI);
            flip = 1;
        end
        else if (r < -longint'(HALF_PI))
        begin
            r += longint'(PI);
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STEPS_DEF && i < 30; i++)
        begin
            if (r >= 0)
            begin
                nx = x - shr(y, i);
                y = y + shr(x, i);
                r -= longint'(atan_q30(5'(i)));
            end
            else
            begin
                nx = x + shr(y, i);
                y = y - shr(x, i);
                r += longint'(atan_q30(5'(i)));
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic predict_pose(input logic [15:0] rr, input logic [15:0] lr,
                                input logic [23:0] dt_in, input logic seen);
        longint dt, rv, lv, vx, vy, phi, c, s, nc, ns;
        pose_t e;
        dt = longint'(dt_in);
        if (seen)
        begin
            rv = clip((longint'(rr) - longint'(p_offset)) * p_gain, 32);
            lv = clip((longint'(lr) - longint'(p_offset)) * p_gain, 32);
            p_speed = shr(rv + lv, 1);
            p_rate = clip(shr((rv - lv) * longint'(p_itw), 16), 32);
        end
        vx = shr(p_speed * p_cos, 30);
        vy = shr(p_speed * p_sin, 30);
        p_x = clip(p_x + shr(vx * dt, 16), 48);
        p_y = clip(p_y + shr(vy * dt, 16), 48);
        phi = p_rate * dt;
        rotate_unit(shr(phi, 2), c, s);
        nc = unit_clip(shr(p_cos * c - p_sin * s, 30));
        ns = unit_clip(shr(p_sin * c + p_cos * s, 30));
        p_cos = nc;
        p_sin = ns;
        p_ang = clip(p_ang + shr(phi, 16), 32);
        e.px = p_x[47:0]; e.py = p_y[47:0]; e.hd = p_ang[31:0];
        e.hc = p_cos[31:0]; e.hs = p_sin[31:0];
        e.ls = p_speed[31:0]; e.tr = p_rate[31:0];
        pose_queue.push_back(e);
    endtask

    // Send one transaction; holds valid across back-to-back items
    task automatic send_item(input logic [15:0] rr, input logic [15:0] lr,
                             input logic [23:0] dt, input logic seen);
        in_valid <= 1'b1;
        right_reading <= rr;
        left_reading <= lr;
        step_time <= dt;
        readings_seen <= seen;
        do @(posedge clk); while (in_stall);
        predict_pose(rr, lr, dt, seen);
        n_sent++;
        @(negedge clk);
    endtask

    task automatic idle_gap(input int n);
        in_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pose_queue.size() != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] v);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 4'(idx) << 2; pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_SPEED_OFFSET: p_offset = v[15:0];
            REG_SPEED_GAIN:   p_gain = longint'(signed'(v));
            REG_INV_TRACK:    p_itw = v[30:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] off, input logic [31:0] gain,
                              input logic [30:0] itw);
        write_reg(REG_SPEED_OFFSET, {16'd0, off});
        write_reg(REG_SPEED_GAIN, gain);
        write_reg(REG_INV_TRACK, {1'b0, itw});
    endtask

    // Random item, readings mostly present, small steps usually
    task automatic send_random();
        logic [23:0] dt;
        case ($urandom_range(0, 5))
            0: dt = 24'($urandom);
            1: dt = 24'd0;
            default: dt = 24'($urandom_range(0, 4000));
        endcase
        send_item(16'($urandom), 16'($urandom), dt, $urandom_range(0, 7) != 0);
    endtask

    task automatic random_bursts(input int n);
        int k;
        k = 0;
        while (k < n)
        begin
            for (int b = $urandom_range(1, 8); b > 0 && k < n; b--)
            begin
                send_random();
                k++;
            end
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 40));
        end
    endtask

    // Tests
    task automatic test_reset_defaults();
        send_item(16'd0, 16'd0, 24'd0, 1'b0);
        send_item(16'd3, 16'd1, 24'd65536, 1'b1);
        send_item(16'd3, 16'd1, 24'd65536, 1'b0);
        send_item(16'hffff, 16'h0000, 24'hffffff, 1'b1);
        send_item(16'h0000, 16'hffff, 24'hffffff, 1'b1);
        send_item(16'hffff, 16'hffff, 24'h000001, 1'b1);
        wait_drained();
    endtask

    task automatic test_register_extremes();
        set_config(16'hffff, 32'h7fffffff, 31'h7fffffff);
        send_item(16'h0000, 16'hffff, 24'hffffff, 1'b1);
        send_item(16'hffff, 16'h0000, 24'hffffff, 1'b1);
        send_item(16'h1234, 16'h4321, 24'd0, 1'b1);
        wait_drained();
        set_config(16'h0000, 32'h80000000, 31'h0);
        send_item(16'hffff, 16'h0001, 24'hffffff, 1'b1);
        send_item(16'h8000, 16'h7fff, 24'h800000, 1'b0);
        wait_drained();
        set_config(16'h8000, 32'd0, 31'd1);
        send_item(16'h5555, 16'haaaa, 24'h555555, 1'b1);
        send_item(16'haaaa, 16'h5555, 24'haaaaaa, 1'b1);
        wait_drained();
    endtask

    task automatic test_heading_wrap();
        // steps of about a third of a turn walk the cos/sin heading pair past +-pi
        set_config(16'd32768, 32'd655, 31'd200000);
        for (int i = 0; i < 10; i++)
            send_item(16'd40000, 16'd25000, 24'd30000, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_phases();
        set_config(16'd32768, 32'd64, 31'd131072);
        random_bursts(300);
        wait_drained();
        set_config(16'($urandom), 32'($urandom), 31'($urandom));
        random_bursts(300);
        wait_drained();
    endtask

    task automatic test_backpressure();
        set_config(16'd30000, 32'd300, 31'd90000);
        hold_cycles = 3000;
        stall_mode = 2;
        random_bursts(40);
        while (stall_mode == 2) @(negedge clk);
        wait_drained();
        stall_mode = 1;
        random_bursts(150);
        stall_mode = 0;
        random_bursts(150);
        wait_drained();
    endtask

    // Receiver stall pattern
    always @(negedge clk)
    begin
        if (stall_mode == 2)
        begin
            out_stall <= 1'b1;
            if (hold_cycles > 0) hold_cycles--;
            else stall_mode = 0;
        end
        else if (stall_mode == 1)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 3) == 0);
    end

    // Result checker
    always @(posedge clk)
    begin
        pose_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pose_queue.size() == 0)
            begin
                $error("unexpected result transaction");
                errors++;
            end
            else
            begin
                e = pose_queue.pop_front();
                n_checked++;
                if (pos_x !== e.px) begin $error("pos_x exp %0d got %0d", e.px, pos_x); errors++; end
                if (pos_y !== e.py) begin $error("pos_y exp %0d got %0d", e.py, pos_y); errors++; end
                if (heading !== e.hd) begin $error("heading exp %0d got %0d", e.hd, heading); errors++; end
                if (heading_cos !== e.hc)
                begin
                    $error("heading_cos exp %0d got %0d", e.hc, heading_cos);
                    errors++;
                end
                if (heading_sin !== e.hs)
                begin
                    $error("heading_sin exp %0d got %0d", e.hs, heading_sin);
                    errors++;
                end
                if (linear_speed !== e.ls)
                begin
                    $error("linear_speed exp %0d got %0d", e.ls, linear_speed);
                    errors++;
                end
                if (turn_rate !== e.tr)
                begin
                    $error("turn_rate exp %0d got %0d", e.tr, turn_rate);
                    errors++;
                end
            end
        end
    end

    // Timeout watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CLK_LIMIT)
        begin
            $display("tb_diff_drive_odometry: done, errors");
            $finish;
        end
    end

    initial
    begin
        p_offset = 0; p_gain = 65536; p_itw = 65536;
        p_x = 0; p_y = 0; p_ang = 0; p_cos = 1073741824; p_sin = 0;
        p_speed = 0; p_rate = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_reset_defaults();
        test_register_extremes();
        test_heading_wrap();
        test_random_phases();
        test_backpressure();
        $display("sent %0d items, checked %0d results over several register settings",
                 n_sent, n_checked);
        if (errors == 0 && pose_queue.size() == 0)
            $display("tb_diff_drive_odometry: done, clean");
        else
            $display("tb_diff_drive_odometry: done, errors");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+design
design/odo_pkg.sv
design/odo_mul.sv
design/diff_drive_odometry.sv
tb/tb_diff_drive_odometry.sv
